[rtl/rct_pkg.sv]
// rct_pkg: shared types and constants for the remote code table
// used by rct_table, rct_ctrl and remote_code_table_unit; no dependencies
`default_nettype none

package rct_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int KEY_W     = 24;
  localparam int WORD_W    = 32;
  localparam int FLAGS_W   = 8;
  localparam int SLOT_W    = 4;

  localparam logic [KEY_W-1:0]   EMPTY_KEY   = 24'hFF_FFFF;
  localparam logic [7:0]         NIBBLE_MASK = 8'hF0;
  localparam logic [FLAGS_W-1:0] FLAGS_CLEAR = 8'h00;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_ERASE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_PRESENT  = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic wr;   // write key with clear flags, mark slot used
    logic inv;  // mark slot empty
    logic clr;  // empty every slot
  } tbl_cmd_t;

  typedef struct packed {
    logic [FLAGS_W-1:0] entry_flags;
    logic [SLOT_W-1:0]  slot_index;
    logic               found;
    status_t            status;
  } rct_result_t;

  function automatic int idx_width(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

`default_nettype wire

[rtl/rct_table.sv]
// rct_table: slot memory with one read/write port and registered read data
// per-slot used bits let a clear empty every slot at once; depends on rct_pkg
`default_nettype none

module rct_table
  import rct_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire tbl_cmd_t                    cmd,
  input  wire logic [idx_width(SLOTS)-1:0] addr,
  input  wire logic [WORD_W-1:0]           wr_data,
  output logic      [WORD_W-1:0]           rd_data
);

  logic [WORD_W-1:0] mem [SLOTS];
  logic [SLOTS-1:0]  used;
  logic [WORD_W-1:0] rd_word;
  logic              rd_used;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[addr] <= wr_data;
    end
    rd_word <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      used <= '0;
    end else if (cmd.wr) begin
      used[addr] <= 1'b1;
    end else if (cmd.inv) begin
      used[addr] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_used <= 1'b0;
    end else begin
      rd_used <= used[addr];
    end
  end

  // an unused slot reads as the empty word
  assign rd_data = rd_used ? rd_word : {WORD_W{1'b1}};

endmodule

`default_nettype wire

[rtl/rct_ctrl.sv]
// rct_ctrl: sequencer that scans the table one slot per cycle through a
// single key comparator, then issues the table update and the result; uses rct_pkg
`default_nettype none

module rct_ctrl
  import rct_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire op_t                         in_op,
  input  wire logic [KEY_W-1:0]            in_code,
  output logic                             res_valid,
  input  wire logic                        res_ready,
  output rct_result_t                      res,
  output tbl_cmd_t                         tbl_cmd,
  output logic      [idx_width(SLOTS)-1:0] tbl_addr,
  output logic      [WORD_W-1:0]           tbl_wr_data,
  input  wire logic [WORD_W-1:0]           tbl_rd_data
);

  localparam int IW = idx_width(SLOTS);
  localparam logic [IW-1:0] LAST_IDX  = IW'(SLOTS - 1);
  localparam logic [IW:0]   CNT_LIMIT = (IW + 1)'(SLOTS);

  state_t state, state_next;

  op_t                op_q;
  logic [KEY_W-1:0]   key_q;
  logic [IW:0]        cnt;
  logic               chk_vld;
  logic [IW-1:0]      chk_idx;
  logic               hit_found;
  logic [IW-1:0]      hit_idx;
  logic [FLAGS_W-1:0] hit_flags;
  logic               empty_found;
  logic [IW-1:0]      empty_idx;

  logic accept;
  logic scan_done;
  logic key_match;
  logic slot_empty;
  logic fire;

  assign accept    = in_valid && in_ready;
  assign scan_done = chk_vld && (chk_idx == LAST_IDX);
  assign fire      = (state == S_FINISH) && res_ready;

  // the shared compare unit
  assign key_match  = (tbl_rd_data[KEY_W-1:0] == key_q);
  assign slot_empty = (tbl_rd_data[KEY_W-1:0] == EMPTY_KEY);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (in_op == OP_ERASE) ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt         <= '0;
      chk_vld     <= 1'b0;
      hit_found   <= 1'b0;
      empty_found <= 1'b0;
      op_q        <= OP_ADD;
    end else if (accept) begin
      cnt         <= '0;
      chk_vld     <= 1'b0;
      hit_found   <= 1'b0;
      empty_found <= 1'b0;
      op_q        <= in_op;
    end else begin
      chk_vld <= (state == S_SCAN) && (cnt < CNT_LIMIT);
      if ((state == S_SCAN) && (cnt < CNT_LIMIT)) begin
        cnt <= cnt + 1'b1;
      end
      // keep only the lowest matching and lowest empty slot
      if (chk_vld && key_match && !hit_found) begin
        hit_found <= 1'b1;
      end
      if (chk_vld && slot_empty && !empty_found) begin
        empty_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_q <= {in_code[KEY_W-1:16] & NIBBLE_MASK, in_code[15:0]};
    end
    chk_idx <= cnt[IW-1:0];
    if (chk_vld && key_match && !hit_found) begin
      hit_idx   <= chk_idx;
      hit_flags <= tbl_rd_data[WORD_W-1:KEY_W];
    end
    if (chk_vld && slot_empty && !empty_found) begin
      empty_idx <= chk_idx;
    end
  end

  always_comb begin
    in_ready    = (state == S_IDLE);
    res_valid   = (state == S_FINISH);
    tbl_cmd     = '0;
    tbl_addr    = cnt[IW-1:0];
    tbl_wr_data = {FLAGS_CLEAR, key_q};
    res         = '{entry_flags: FLAGS_CLEAR, slot_index: '0, found: 1'b0,
                    status: ST_OK};
    if (state == S_FINISH) begin
      tbl_addr = (op_q == OP_ADD) ? empty_idx : hit_idx;
      unique case (op_q)
        OP_ADD: begin
          if (hit_found) begin
            res.status     = ST_PRESENT;
            res.found      = 1'b1;
            res.slot_index = SLOT_W'(hit_idx);
          end else if (!empty_found) begin
            res.status = ST_FULL;
          end else begin
            res.slot_index = SLOT_W'(empty_idx);
            tbl_cmd.wr     = fire;
          end
        end
        OP_REMOVE, OP_LOOKUP: begin
          if (hit_found) begin
            res.found      = 1'b1;
            res.slot_index = SLOT_W'(hit_idx);
            if (op_q == OP_LOOKUP) begin
              res.entry_flags = hit_flags;
            end else begin
              tbl_cmd.inv = fire;
            end
          end else begin
            res.status = ST_NOTFOUND;
          end
        end
        OP_ERASE: begin
          tbl_cmd.clr = fire;
        end
        default: res.status = ST_OK;
      endcase
    end
  end

  a_wr_only_on_free_add: assert property (@(posedge clk) disable iff (rst)
    tbl_cmd.wr |-> (op_q == OP_ADD) && !hit_found && empty_found)
    else $error("table write without a free slot or with a duplicate");

  a_inv_only_on_hit: assert property (@(posedge clk) disable iff (rst)
    tbl_cmd.inv |-> (op_q == OP_REMOVE) && hit_found)
    else $error("slot emptied without a matching key");

  a_check_follows_scan: assert property (@(posedge clk) disable iff (rst)
    chk_vld |-> $past(state == S_SCAN))
    else $error("compare outside of a scan");

  a_finish_after_full_scan: assert property (@(posedge clk) disable iff (rst)
    ((state == S_FINISH) && ($past(state) == S_SCAN)) |->
      $past(chk_vld && (chk_idx == LAST_IDX)))
    else $error("scan ended before the last slot was compared");

endmodule

`default_nettype wire

[rtl/remote_code_table_unit.sv]
// remote_code_table_unit: top level of the learned remote code table
// instantiates rct_ctrl and rct_table and holds the output register; uses rct_pkg
//
// usage
//   s_* carries one command per transaction: s_tuser is the operation
//   (add, remove, lookup, erase all) and s_tdata the three code bytes; the
//   low nibble of the third byte is ignored. m_* returns exactly one result
//   per command: status, found, slot index and flag byte.
// timing
//   add, remove and lookup scan the table one slot per cycle through a
//   single comparator on the registered memory read port; erase all skips
//   the scan. s_tready is high only while idle, so a new command is taken
//   only after the previous result has passed to the output register.
// reset
//   rst empties every slot at once through the per-slot used bits; no
//   clearing pass is needed and the block is ready in the next cycle.
// stall
//   a finished result sits in the output register until m_tready; the
//   sequencer holds its last step until that register is free.
`default_nettype none

module remote_code_table_unit
  import rct_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // code_byte0, code_byte1, code_byte2
  input  wire logic [1:0]  s_tuser,   // operation
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [15:0] m_tdata    // status, found, slot_index, entry_flags, zero pad
);

  localparam int IW = idx_width(SLOTS);

  logic              res_valid;
  logic              res_ready;
  rct_result_t       res;
  tbl_cmd_t          tbl_cmd;
  logic [IW-1:0]     tbl_addr;
  logic [WORD_W-1:0] tbl_wr_data;
  logic [WORD_W-1:0] tbl_rd_data;
  rct_result_t       out_q;

  assign res_ready = !m_tvalid || m_tready;

  rct_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_op       (op_t'(s_tuser)),
    .in_code     (s_tdata),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .tbl_cmd     (tbl_cmd),
    .tbl_addr    (tbl_addr),
    .tbl_wr_data (tbl_wr_data),
    .tbl_rd_data (tbl_rd_data)
  );

  rct_table #(
    .SLOTS (SLOTS)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .cmd     (tbl_cmd),
    .addr    (tbl_addr),
    .wr_data (tbl_wr_data),
    .rd_data (tbl_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_tdata = {1'b0, out_q};

endmodule

`default_nettype wire

[test/testbench.sv]
// testbench: self-checking bench for remote_code_table_unit
// predicts every result from a local copy of the code table; uses rct_pkg
`timescale 1ns / 1ps

module testbench;
  import rct_pkg::*;

  localparam int NUM_SLOTS   = SLOTS_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int POOL_SIZE   = 24;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // code_byte0, code_byte1, code_byte2
  logic [1:0]  s_tuser;   // operation
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // status, found, slot_index, entry_flags, zero pad

  // local copy of the table: key bytes and flag byte per slot
  logic [23:0] key_store  [NUM_SLOTS];
  logic [7:0]  flag_store [NUM_SLOTS];
  logic [23:0] key_pool   [POOL_SIZE];

  rct_result_t pending_results[$];
  int          error_count = 0;
  int          idle_cycles = 0;
  bit          quiet_phase = 1'b0;

  remote_code_table_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void empty_all_slots();
    for (int i = 0; i < NUM_SLOTS; i++) begin
      key_store[i]  = EMPTY_KEY;
      flag_store[i] = 8'hFF;
    end
  endfunction

  // applies one command to the local table and returns the result it causes
  function automatic rct_result_t predict_table_op(input op_t op, input logic [23:0] code);
    logic [23:0] key;
    int          hit;
    int          vacant;
    rct_result_t res;
    key    = {code[23:16] & NIBBLE_MASK, code[15:0]};
    res    = '0;
    hit    = -1;
    vacant = -1;
    if (op == OP_ERASE) begin
      empty_all_slots();
      return res;
    end
    // walk downward so the lowest matching and lowest empty slot win
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (key_store[i] == key) hit = i;
      if (key_store[i] == EMPTY_KEY) vacant = i;
    end
    case (op)
      OP_ADD: begin
        if (hit >= 0) begin
          res.status     = ST_PRESENT;
          res.found      = 1'b1;
          res.slot_index = hit[SLOT_W-1:0];
        end else if (vacant < 0) begin
          res.status = ST_FULL;
        end else begin
          key_store[vacant]  = key;
          flag_store[vacant] = FLAGS_CLEAR;
          res.status         = ST_OK;
          res.slot_index     = vacant[SLOT_W-1:0];
        end
      end
      OP_REMOVE: begin
        if (hit < 0) begin
          res.status = ST_NOTFOUND;
        end else begin
          key_store[hit]  = EMPTY_KEY;
          flag_store[hit] = 8'hFF;
          res.status      = ST_OK;
          res.found       = 1'b1;
          res.slot_index  = hit[SLOT_W-1:0];
        end
      end
      default: begin
        if (hit < 0) begin
          res.status = ST_NOTFOUND;
        end else begin
          res.status      = ST_OK;
          res.found       = 1'b1;
          res.slot_index  = hit[SLOT_W-1:0];
          res.entry_flags = flag_store[hit];
        end
      end
    endcase
    return res;
  endfunction

  // valid stays high between back-to-back commands; it drops only for a gap
  task automatic send_cmd(input op_t op, input logic [23:0] code);
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= code;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(predict_table_op(op, code));
  endtask

  // result side backpressure
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet_phase && $urandom_range(0, 9) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    rct_result_t got;
    rct_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = rct_result_t'(m_tdata[14:0]);
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected: %h", m_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          error_count++;
        end
        if (got.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, got.found);
          error_count++;
        end
        if (got.slot_index !== want.slot_index) begin
          $error("slot_index: expected %0d, got %0d", want.slot_index, got.slot_index);
          error_count++;
        end
        if (got.entry_flags !== want.entry_flags) begin
          $error("entry_flags: expected %h, got %h", want.entry_flags, got.entry_flags);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic test_empty_after_reset();
    send_cmd(OP_LOOKUP, 24'hFF_FFFF);
    send_cmd(OP_REMOVE, 24'h00_0000);
  endtask

  // extreme keys first, then fill every slot, then duplicate and full
  task automatic test_fill_to_full();
    send_cmd(OP_ADD, 24'h00_0000);
    send_cmd(OP_ADD, 24'hFF_FFFF);
    for (int i = 2; i < NUM_SLOTS; i++) begin
      send_cmd(OP_ADD, {8'(i * 16 + 3), 8'(~i), 8'(i * 37)});
    end
    send_cmd(OP_ADD, 24'h00_0000);
    send_cmd(OP_ADD, 24'h12_3456);
  endtask

  task automatic test_remove_and_reuse();
    send_cmd(OP_LOOKUP, 24'hF0_FFFF);
    send_cmd(OP_REMOVE, 24'hFA_FFFF);
    send_cmd(OP_REMOVE, 24'hFF_FFFF);
    send_cmd(OP_ADD, 24'h5A_A55A);
  endtask

  task automatic test_nibble_mask();
    // low nibble of the third byte must not take part in the match
    send_cmd(OP_LOOKUP, 24'h0F_0000);
  endtask

  task automatic test_erase_all();
    send_cmd(OP_ERASE, 24'hA5_5AA5);
    send_cmd(OP_LOOKUP, 24'h00_0000);
  endtask

  // mostly keys from a small pool so adds collide and the table fills up
  task automatic test_random_traffic(input int count);
    int          pick;
    int          k;
    op_t         op;
    logic [23:0] code;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = 24'($urandom);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) op = OP_ADD;
      else if (pick < 65) op = OP_REMOVE;
      else if (pick < 99) op = OP_LOOKUP;
      else op = OP_ERASE;
      if ($urandom_range(0, 99) < 8) begin
        code = 24'($urandom);
      end else begin
        k    = $urandom_range(0, POOL_SIZE - 1);
        code = {key_pool[k][23:20], 4'($urandom), key_pool[k][15:0]};
      end
      send_cmd(op, code);
    end
  endtask

  initial begin
    empty_all_slots();
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= OP_ADD;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_empty_after_reset();
    test_fill_to_full();
    test_remove_and_reuse();
    test_nibble_mask();
    test_erase_all();
    test_random_traffic(1420);
    quiet_phase = 1'b1;
    test_random_traffic(200);
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
